>>> rtl/core/cdo_pkg.sv
// Shared types and constants for the calendar date day-offset block.
// Used by cdo_ctrl, cdo_dpath and the calendar_date_day_offset top level.
package cdo_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MIN = 4'd1;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [4:0]  DAY_MIN   = 5'd1;
  localparam logic [4:0]  DAY_MAX   = 5'd31;
  localparam logic [6:0]  YIC_MAX   = 7'd99;

  // floor(y / 100) == (y * CENT_RECIP) >> CENT_SHIFT for y in 0..9999
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int unsigned CENT_SHIFT = 19;
  localparam int unsigned PROD_BITS  = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CLAMP,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic split;
    logic clamp;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } sts_t;

  function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/core/calendar_date_day_offset.sv
// Gregorian date plus or minus a day count: one transaction in, one out.
// An accepted input transaction passes these states before the next one is taken:
// ST_IDLE registers the date and the reciprocal product for the century split,
// ST_SPLIT splits the year into century and year-in-century, ST_CLAMP clamps
// the day, ST_STEP steps the days until the count is zero, ST_DONE loads the
// output register once it is free. Stepping is one day per cycle through the datapath's
// date counters and stops early at 0000-01-01 or 9999-12-31. The result sits
// in an output register, so a stalled result does not block the next input.
// Depends on cdo_pkg, cdo_ctrl and cdo_dpath.
module calendar_date_day_offset (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic        in_go_back,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_end_year,
  output logic [3:0]  out_end_month,
  output logic [4:0]  out_end_day,
  output logic        out_out_of_range
);
  import cdo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cdo_dpath u_dpath (
    .clk              (clk),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_go_back       (in_go_back),
    .in_day_count     (in_day_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_end_year     (out_end_year),
    .out_end_month    (out_end_month),
    .out_end_day      (out_end_day),
    .out_out_of_range (out_out_of_range)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in progress");

  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_month >= MONTH_MIN) && (out_end_month <= MONTH_MAX))
    else $error("result month outside 1..12");

  a_day_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_day >= DAY_MIN) && (out_end_day <= DAY_MAX))
    else $error("result day outside 1..31");

  a_year_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_year <= YEAR_MAX))
    else $error("result year above 9999");
`endif

endmodule

>>> rtl/core/cdo_ctrl.sv
// Sequencing state machine for the calendar date day-offset block.
// Depends on cdo_pkg; drives cdo_dpath through cmd_t and reads sts_t.
module cdo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cdo_pkg::cmd_t cmd,
  input  cdo_pkg::sts_t sts
);
  import cdo_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (sts.count_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        // hand over only once the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.publish | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/cdo_dpath.sv
// Date registers, leap-year tracking and day stepping for the day-offset block.
// Depends on cdo_pkg; controlled by cdo_ctrl through cmd_t.
module cdo_dpath (
  input  logic                   clk,
  input  logic [13:0]            in_start_year,
  input  logic [3:0]             in_start_month,
  input  logic [4:0]             in_start_day,
  input  logic                   in_go_back,
  input  logic [15:0]            in_day_count,
  input  cdo_pkg::cmd_t          cmd,
  output cdo_pkg::sts_t          sts,
  output logic [13:0]            out_end_year,
  output logic [3:0]             out_end_month,
  output logic [4:0]             out_end_day,
  output logic                   out_out_of_range
);
  import cdo_pkg::*;

  logic [13:0]           year_r, year_nxt;
  logic [3:0]            month_r, month_nxt;
  logic [4:0]            day_r, day_nxt;
  logic                  back_r, back_nxt;
  logic                  flag_r, flag_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [6:0]            cent_r, cent_nxt;   // year / 100
  logic [6:0]            yic_r, yic_nxt;     // year % 100
  logic [13:0]           oyear_r;
  logic [3:0]            omonth_r;
  logic [4:0]            oday_r;
  logic                  oflag_r;

  logic        leap;
  logic [4:0]  dim;
  logic [4:0]  dim_prev;
  logic [13:0] year_sat;
  logic        year_over;
  logic [13:0] hundreds;
  logic [6:0]  split_cent;

  assign leap     = (yic_r[1:0] == 2'd0) && ((yic_r != 7'd0) || (cent_r[1:0] == 2'd0));
  assign dim      = days_in(leap, month_r);
  assign dim_prev = days_in(leap, month_r - 4'd1);

  assign year_over  = in_start_year > YEAR_MAX;
  assign year_sat   = year_over ? YEAR_MAX : in_start_year;
  assign split_cent = prod_r[PROD_BITS-1:CENT_SHIFT];
  assign hundreds   = 14'({7'd0, split_cent} * 14'd100);

  assign sts.count_zero = (count_r == '0);

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    back_nxt  = back_r;
    flag_nxt  = flag_r;
    count_nxt = count_r;
    prod_nxt  = prod_r;
    cent_nxt  = cent_r;
    yic_nxt   = yic_r;

    if (cmd.load) begin
      year_nxt  = year_sat;
      flag_nxt  = year_over;
      back_nxt  = in_go_back;
      count_nxt = year_over ? '0 : COUNT_BITS'(in_day_count);
      prod_nxt  = PROD_BITS'(year_sat) * PROD_BITS'(CENT_RECIP);
      if (in_start_month < MONTH_MIN) begin
        month_nxt = MONTH_MIN;
      end else if (in_start_month > MONTH_MAX) begin
        month_nxt = MONTH_MAX;
      end else begin
        month_nxt = in_start_month;
      end
      day_nxt = (in_start_day < DAY_MIN) ? DAY_MIN : in_start_day;
    end

    if (cmd.split) begin
      cent_nxt = split_cent;
      yic_nxt  = 7'(year_r - hundreds);
    end

    if (cmd.clamp && (day_r > dim)) begin
      day_nxt = dim;
    end

    if (cmd.step) begin
      count_nxt = count_r - COUNT_BITS'(1);
      if (!back_r) begin
        if (day_r < dim) begin
          day_nxt = day_r + 5'd1;
        end else if (month_r < MONTH_MAX) begin
          month_nxt = month_r + 4'd1;
          day_nxt   = DAY_MIN;
        end else if (year_r < YEAR_MAX) begin
          year_nxt  = year_r + 14'd1;
          month_nxt = MONTH_MIN;
          day_nxt   = DAY_MIN;
          if (yic_r == YIC_MAX) begin
            yic_nxt  = 7'd0;
            cent_nxt = cent_r + 7'd1;
          end else begin
            yic_nxt = yic_r + 7'd1;
          end
        end else begin
          // stuck at the last date: drop the remaining days
          flag_nxt  = 1'b1;
          count_nxt = '0;
        end
      end else begin
        if (day_r >= 5'd2) begin
          day_nxt = day_r - 5'd1;
        end else if (month_r > MONTH_MIN) begin
          month_nxt = month_r - 4'd1;
          day_nxt   = dim_prev;
        end else if (year_r > 14'd0) begin
          year_nxt  = year_r - 14'd1;
          month_nxt = MONTH_MAX;
          day_nxt   = DAY_MAX;
          if (yic_r == 7'd0) begin
            yic_nxt  = YIC_MAX;
            cent_nxt = cent_r - 7'd1;
          end else begin
            yic_nxt = yic_r - 7'd1;
          end
        end else begin
          flag_nxt  = 1'b1;
          count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    back_r  <= back_nxt;
    flag_r  <= flag_nxt;
    count_r <= count_nxt;
    prod_r  <= prod_nxt;
    cent_r  <= cent_nxt;
    yic_r   <= yic_nxt;
    if (cmd.publish) begin
      oyear_r  <= year_r;
      omonth_r <= month_r;
      oday_r   <= day_r;
      oflag_r  <= flag_r;
    end
  end

  assign out_end_year     = oyear_r;
  assign out_end_month    = omonth_r;
  assign out_end_day      = oday_r;
  assign out_out_of_range = oflag_r;

endmodule

>>> verif/cdo_date_checker.sv
// Checker for calendar_date_day_offset: watches both channels, predicts each result date
// from the accepted start date and compares it field by field. Depends on cdo_pkg.
`timescale 1ns / 1ps
module cdo_date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic        in_go_back,
  input  logic [15:0] in_day_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [13:0] out_end_year,
  input  logic [3:0]  out_end_month,
  input  logic [4:0]  out_end_day,
  input  logic        out_out_of_range,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          limit_count
);
  import cdo_pkg::*;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        oor;
  } date_result_t;

  date_result_t expected_dates[$];

  assign pending = expected_dates.size();

  initial begin
    fail_count    = 0;
    checked_count = 0;
    limit_count   = 0;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      MONTH_FEB:         len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:       len = 30;
      default:           len = 31;
    endcase
    return len;
  endfunction

  function automatic date_result_t shift_date(input logic [13:0] y0, input logic [3:0] m0,
                                              input logic [4:0] d0, input logic back,
                                              input logic [15:0] cnt);
    int unsigned  y;
    int unsigned  m;
    int unsigned  d;
    int unsigned  n;
    bit           hit;
    date_result_t r;
    y = 32'(y0);
    m = 32'(m0);
    d = 32'(d0);
    n = 32'(cnt) & ((32'd1 << COUNT_BITS) - 1);
    r.oor = 1'b0;
    // saturate an impossible year and skip stepping altogether
    if (y > YEAR_MAX) begin
      y = 32'(YEAR_MAX);
      r.oor = 1'b1;
      n = 0;
    end
    if (m < MONTH_MIN) m = 32'(MONTH_MIN);
    if (m > MONTH_MAX) m = 32'(MONTH_MAX);
    if (d < DAY_MIN) d = 32'(DAY_MIN);
    if (d > days_of_month(y, m)) d = days_of_month(y, m);
    while (n != 0) begin
      hit = 1'b0;
      if (!back) begin
        if (d < days_of_month(y, m)) d++;
        else if (m < MONTH_MAX) begin
          m++;
          d = 32'(DAY_MIN);
        end else if (y < YEAR_MAX) begin
          y++;
          m = 32'(MONTH_MIN);
          d = 32'(DAY_MIN);
        end else hit = 1'b1;
      end else begin
        if (d >= 2) d--;
        else if (m > MONTH_MIN) begin
          m--;
          d = days_of_month(y, m);
        end else if (y > 0) begin
          y--;
          m = 32'(MONTH_MAX);
          d = 32'(DAY_MAX);
        end else hit = 1'b1;
      end
      // drop the remaining days once a year limit is reached
      if (hit) begin
        r.oor = 1'b1;
        n = 0;
      end else n--;
    end
    r.year  = y[13:0];
    r.month = m[3:0];
    r.day   = d[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    date_result_t got;
    if (rst_n && in_valid && !in_stall)
      expected_dates.push_back(shift_date(in_start_year, in_start_month, in_start_day,
                                          in_go_back, in_day_count));
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_end_year, out_end_month, out_end_day, out_out_of_range};
      if (got.oor) limit_count++;
      if (expected_dates.size() == 0) begin
        $display("%0t: unexpected result transaction %0d-%0d-%0d oor=%0b", $time,
                 got.year, got.month, got.day, got.oor);
        fail_count++;
      end else begin
        want = expected_dates.pop_front();
        checked_count++;
        if (got.year !== want.year) begin
          $display("%0t: end_year expected %0d actual %0d", $time, want.year, got.year);
          fail_count++;
        end
        if (got.month !== want.month) begin
          $display("%0t: end_month expected %0d actual %0d", $time, want.month, got.month);
          fail_count++;
        end
        if (got.day !== want.day) begin
          $display("%0t: end_day expected %0d actual %0d", $time, want.day, got.day);
          fail_count++;
        end
        if (got.oor !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time, want.oor, got.oor);
          fail_count++;
        end
      end
    end
  end

endmodule

>>> verif/tb_calendar_date_day_offset.sv
// Testbench top for calendar_date_day_offset: drives directed and random date offsets
// under several idling mixes and gives the verdict. Depends on cdo_pkg and cdo_date_checker.
`timescale 1ns / 1ps
module tb_calendar_date_day_offset;
  import cdo_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 19;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [13:0] in_start_year  = '0;
  logic [3:0]  in_start_month = '0;
  logic [4:0]  in_start_day   = '0;
  logic        in_go_back     = 1'b0;
  logic [15:0] in_day_count   = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [13:0] out_end_year;
  logic [3:0]  out_end_month;
  logic [4:0]  out_end_day;
  logic        out_out_of_range;

  int fail_count;
  int pending;
  int checked_count;
  int limit_count;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int sent_count  = 0;
  int directed_count;
  int long_left   = 4;

  calendar_date_day_offset dut (.*);

  cdo_date_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Hold each date until the block takes it; idle first as the phase asks.
  task automatic offer_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d,
                            input logic back, input logic [15:0] cnt);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= y;
    in_start_month <= m;
    in_start_day   <= d;
    in_go_back     <= back;
    in_day_count   <= cnt;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic offer_random_date();
    int          kind;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [15:0] cnt;
    kind = $urandom_range(0, 99);
    y    = 14'($urandom_range(0, YEAR_MAX));
    m    = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
    d    = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                       : 5'($urandom_range(1, 28));
    cnt  = 16'($urandom_range(0, 400));
    if (kind < 60) begin
      // plain well-formed offset
    end else if (kind < 75) begin
      // run towards a year limit
      y   = $urandom_range(0, 1) ? 14'($urandom_range(0, 3))
                                 : 14'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
      cnt = 16'($urandom_range(0, 2000));
    end else if (kind < 85) begin
      cnt = 16'($urandom_range(0, 4000));
    end else if (kind < 95) begin
      y   = 14'($urandom_range(0, 16383));
      m   = 4'($urandom_range(0, 15));
      d   = 5'($urandom_range(0, 31));
      cnt = 16'($urandom_range(0, 600));
    end else if (long_left > 0) begin
      long_left--;
      cnt = 16'($urandom_range(32768, 65535));
    end
    offer_date(y, m, d, 1'($urandom_range(0, 1)), cnt);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leap rules and month and year rollover
    offer_date(14'd2024, 4'd2, 5'd28, 1'b0, 16'd1);
    offer_date(14'd2023, 4'd2, 5'd28, 1'b0, 16'd1);
    offer_date(14'd1900, 4'd2, 5'd28, 1'b0, 16'd1);
    offer_date(14'd2000, 4'd2, 5'd28, 1'b0, 16'd1);
    offer_date(14'd0,    4'd2, 5'd28, 1'b0, 16'd1);
    offer_date(14'd1999, 4'd12, 5'd31, 1'b0, 16'd1);
    offer_date(14'd2000, 4'd1, 5'd1, 1'b1, 16'd1);
    offer_date(14'd2000, 4'd3, 5'd1, 1'b1, 16'd1);
    // year limits, including early stop with a long count
    offer_date(14'd9999, 4'd12, 5'd31, 1'b0, 16'd1);
    offer_date(14'd0,    4'd1, 5'd1, 1'b1, 16'd1);
    offer_date(14'd9999, 4'd12, 5'd30, 1'b0, 16'hFFFF);
    offer_date(14'd0,    4'd1, 5'd2, 1'b1, 16'hFFFF);
    offer_date(14'd3,    4'd3, 5'd1, 1'b1, 16'd1200);
    offer_date(14'd9990, 4'd1, 5'd1, 1'b0, 16'd5000);
    // out-of-range start fields
    offer_date(14'h3FFF, 4'd15, 5'd31, 1'b0, 16'd100);
    offer_date(14'd10000, 4'd0, 5'd0, 1'b1, 16'd5);
    offer_date(14'd2021, 4'd0, 5'd0, 1'b0, 16'd0);
    offer_date(14'd2021, 4'd15, 5'd31, 1'b1, 16'd0);
    offer_date(14'd2021, 4'd2, 5'd31, 1'b0, 16'd0);
    offer_date(14'd2020, 4'd4, 5'd31, 1'b1, 16'd3);
    offer_date(14'd1000, 4'd1, 5'd31, 1'b0, 16'd0);
    // full-length stepping both ways
    offer_date(14'd2000, 4'd6, 5'd15, 1'b0, 16'hFFFF);
    offer_date(14'd5000, 4'd6, 5'd15, 1'b1, 16'hFFFF);
    offer_date(14'd1234, 4'd5, 5'd17, 1'b1, 16'h5555);
    directed_count = sent_count;
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) offer_random_date();
      drain_results();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d date offsets: %0d directed, the rest random over four idling mixes",
             sent_count, directed_count);
    $display("Compared %0d results, %0d of them stopped at a year limit",
             checked_count, limit_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
